/* rtl/hpw_pkg.sv */
package hpw_pkg;

  // field widths
  localparam int ANGLE_W   = 16;
  localparam int RATE_W    = 16;
  localparam int DRIVE_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int DLIM_W    = 15;
  localparam int ILIM_W    = 24;
  localparam int SUM_W     = 25;
  localparam int DIFF_W    = ANGLE_W + 1;
  localparam int PROD_SHIFT = 15;

  // heading wrap bounds in 1/128 degree
  localparam int HALF_TURN = 23040;
  localparam int FULL_TURN = 46080;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // reset values of the limits
  localparam logic [DLIM_W-1:0] DLIM_RESET = {DLIM_W{1'b1}};
  localparam logic [ILIM_W-1:0] ILIM_RESET = {ILIM_W{1'b1}};

  // default queue depth between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P         = 3'd0,
    CFG_GAIN_I         = 3'd1,
    CFG_GAIN_D         = 3'd2,
    CFG_DRIVE_LIMIT    = 3'd3,
    CFG_INTEGRAL_LIMIT = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [DLIM_W-1:0] drive_limit;
    logic [ILIM_W-1:0] integral_limit;
  } cfg_t;

  // one classified tick on its way to the back end
  typedef struct packed {
    logic signed [ANGLE_W-1:0] err;
    logic signed [SUM_W-1:0]   sum;
    logic signed [RATE_W-1:0]  rate;
  } q_entry_t;

endpackage

/* rtl/hpw_intf.sv */
// input channel: one control tick per item
interface hpw_in_if
  import hpw_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] target_heading;
  logic signed [ANGLE_W-1:0] measured_heading;
  logic signed [RATE_W-1:0]  yaw_rate;

  modport source(output valid, output target_heading, output measured_heading,
                 output yaw_rate, input ready);
  modport sink(input valid, input target_heading, input measured_heading,
               input yaw_rate, output ready);
endinterface

// result channel: one drive value per item
interface hpw_out_if
  import hpw_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;

  modport source(output valid, output drive, input ready);
  modport sink(input valid, input drive, output ready);
endinterface

/* rtl/hpw_front.sv */
module hpw_front
  import hpw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  hpw_in_if.sink            in_ch,
  input  logic [ILIM_W-1:0] integral_limit,
  output logic              push_valid,
  output q_entry_t          push_data,
  input  logic              push_ready
);

  localparam logic signed [DIFF_W-1:0] HALF_P = DIFF_W'(HALF_TURN);
  localparam logic signed [DIFF_W-1:0] HALF_N = -DIFF_W'(HALF_TURN);
  localparam logic signed [DIFF_W-1:0] FULL   = DIFF_W'(FULL_TURN);

  logic signed [SUM_W-1:0]   error_sum_r;
  logic signed [SUM_W-1:0]   error_sum_nxt;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DIFF_W-1:0]  wrapped;
  logic signed [ANGLE_W-1:0] err;
  logic signed [SUM_W:0]     sum_raw;
  logic signed [SUM_W:0]     lim_p;
  logic signed [SUM_W:0]     lim_n;
  logic signed [SUM_W:0]     sum_clamped;
  logic                      accept;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign accept      = in_ch.valid && push_ready;

  // heading error, one turn folded in at most
  always_comb begin
    diff = {in_ch.target_heading[ANGLE_W-1], in_ch.target_heading}
         - {in_ch.measured_heading[ANGLE_W-1], in_ch.measured_heading};
    if (diff > HALF_P) begin
      wrapped = diff - FULL;
    end else if (diff < HALF_N) begin
      wrapped = diff + FULL;
    end else begin
      wrapped = diff;
    end
    err = wrapped[ANGLE_W-1:0];
  end

  // integral update with symmetric clamp
  always_comb begin
    sum_raw = (SUM_W+1)'(err) + (SUM_W+1)'(error_sum_r);
    lim_p   = signed'({2'b00, integral_limit});
    lim_n   = -lim_p;
    if (sum_raw > lim_p) begin
      sum_clamped = lim_p;
    end else if (sum_raw < lim_n) begin
      sum_clamped = lim_n;
    end else begin
      sum_clamped = sum_raw;
    end
    error_sum_nxt = sum_clamped[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= '0;
    end else if (accept) begin
      error_sum_r <= error_sum_nxt;
    end
  end

  // classified item toward the queue
  always_comb begin
    push_data.err  = err;
    push_data.sum  = error_sum_nxt;
    push_data.rate = in_ch.yaw_rate;
  end

endmodule

/* rtl/hpw_queue.sv */
module hpw_queue
  import hpw_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  input  q_entry_t push_data,
  output logic     push_ready,
  output logic     pop_valid,
  output q_entry_t pop_data,
  input  logic     pop_ready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/hpw_back.sv */
module hpw_back
  import hpw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     pop_valid,
  input  q_entry_t pop_data,
  output logic     pop_ready,
  hpw_out_if.source out_ch
);

  localparam int PP_W  = GAIN_W + 1 + ANGLE_W;
  localparam int PI_W  = GAIN_W + 1 + SUM_W;
  localparam int PD_W  = GAIN_W + 1 + RATE_W;
  localparam int ACC_W = PI_W + 2;
  localparam logic signed [ACC_W-1:0] TRUNC_BIAS = ACC_W'((1 << PROD_SHIFT) - 1);

  logic                      s1_v_r, s2_v_r, s3_v_r;
  logic                      s1_rdy, s2_rdy, s3_rdy;
  logic signed [PP_W-1:0]    pp_r, pp_nxt;
  logic signed [PI_W-1:0]    pi_r, pi_nxt;
  logic signed [PD_W-1:0]    pd_r, pd_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   lim_p, lim_n, sat, biased, shifted;
  logic signed [DRIVE_W-1:0] drive_r, drive_nxt;
  logic signed [GAIN_W:0]    gp_s, gi_s, gd_s;

  // stage advance: a stage moves when it is empty or its successor moves
  assign s3_rdy    = !s3_v_r || out_ch.ready;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign pop_ready = s1_rdy;

  // stage 1: three products
  always_comb begin
    gp_s   = signed'({1'b0, cfg.gain_p});
    gi_s   = signed'({1'b0, cfg.gain_i});
    gd_s   = signed'({1'b0, cfg.gain_d});
    pp_nxt = gp_s * pop_data.err;
    pi_nxt = gi_s * pop_data.sum;
    pd_nxt = gd_s * pop_data.rate;
  end

  // stage 2: sum at 2^-15 scale, rate term lifted by 3 bits
  assign acc_nxt = ACC_W'(pp_r) + ACC_W'(pi_r) - (ACC_W'(pd_r) <<< 3);

  // stage 3: saturate then truncate toward zero
  always_comb begin
    lim_p = ACC_W'(signed'({1'b0, cfg.drive_limit, {PROD_SHIFT{1'b0}}}));
    lim_n = -lim_p;
    if (acc_r > lim_p) begin
      sat = lim_p;
    end else if (acc_r < lim_n) begin
      sat = lim_n;
    end else begin
      sat = acc_r;
    end
    biased    = sat[ACC_W-1] ? sat + TRUNC_BIAS : sat;
    shifted   = biased >>> PROD_SHIFT;
    drive_nxt = shifted[DRIVE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= pop_valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      pp_r <= pp_nxt;
      pi_r <= pi_nxt;
      pd_r <= pd_nxt;
    end
    if (s2_rdy) begin
      acc_r <= acc_nxt;
    end
    if (s3_rdy) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_ch.valid = s3_v_r;
  assign out_ch.drive = drive_r;

endmodule

/* rtl/heading_pid_with_wrap.sv */
// Heading PID controller with angle wrap.
// in_ch carries one control tick per item: target heading, measured heading
// (1/128 degree) and yaw rate (1/16 dps). out_ch returns one drive value per
// item, in the same order. An item is taken when valid and ready are high.
// Gains and limits are written through cfg_we / cfg_index / cfg_data; the
// user must do so only while idle, which the block does not enforce. Index
// 0..4 selects gain_p, gain_i, gain_d, drive_limit, integral_limit, other
// indexes are ignored. Throughput: one item per cycle while the queue has
// room. The integral register is updated in the cycle an item is accepted,
// so consecutive ticks chain through that one add-and-clamp. An item passes
// the queue, product stage, sum stage and saturate/truncate stage in turn.
// Reset (rst_n low, synchronous) clears the integral, empties the queue and
// pipeline, zeroes the gains and sets both limits to full scale.
// When the receiver stalls, the back pipeline holds and the front keeps
// taking items until the QUEUE_DEPTH-entry queue between them fills.
module heading_pid_with_wrap
  import hpw_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hpw_in_if.sink                in_ch,
  hpw_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg_r;
  logic     push_valid, push_ready;
  logic     pop_valid, pop_ready;
  q_entry_t push_data, pop_data;

  // configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= '0;
      cfg_r.gain_i         <= '0;
      cfg_r.gain_d         <= '0;
      cfg_r.drive_limit    <= DLIM_RESET;
      cfg_r.integral_limit <= ILIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_P:         cfg_r.gain_p         <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:         cfg_r.gain_i         <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:         cfg_r.gain_d         <= cfg_data[GAIN_W-1:0];
        CFG_DRIVE_LIMIT:    cfg_r.drive_limit    <= cfg_data[DLIM_W-1:0];
        CFG_INTEGRAL_LIMIT: cfg_r.integral_limit <= cfg_data[ILIM_W-1:0];
        default: ;
      endcase
    end
  end

  // front: wrap and integrate
  hpw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .integral_limit (cfg_r.integral_limit),
    .push_valid     (push_valid),
    .push_data      (push_data),
    .push_ready     (push_ready)
  );

  // decoupling queue
  hpw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // back: products, sum, saturation
  hpw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb
  import hpw_pkg::*;
;

  typedef logic signed [DRIVE_W-1:0] drive_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] target;
    logic signed [ANGLE_W-1:0] measured;
    logic signed [RATE_W-1:0]  rate;
  } tick_t;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int RANDOM_PHASES   = 8;
  localparam int TICKS_PER_PHASE = 50;
  localparam int SETTLE_CYCLES   = 6;
  localparam int MAX_WAIT        = 5;
  localparam int REPORT_MAX      = 10;
  localparam int SPARE_INDEX_LO  = int'(CFG_INTEGRAL_LIMIT) + 1;

  logic clk;
  logic rst_n = 1'b0;

  // stimulus side of the channels and the register port
  logic                      tick_valid    = 1'b0;
  logic signed [ANGLE_W-1:0] tick_target   = '0;
  logic signed [ANGLE_W-1:0] tick_measured = '0;
  logic signed [RATE_W-1:0]  tick_rate     = '0;
  logic                      drive_ready   = 1'b0;
  logic                      cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index     = '0;
  logic [CFG_DATA_W-1:0]     cfg_data      = '0;

  hpw_in_if  in_if ();
  hpw_out_if out_if ();

  assign in_if.valid            = tick_valid;
  assign in_if.target_heading   = tick_target;
  assign in_if.measured_heading = tick_measured;
  assign in_if.yaw_rate         = tick_rate;
  assign out_if.ready           = drive_ready;

  heading_pid_with_wrap dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // controller copy: gains, limits and integral
  logic [GAIN_W-1:0] kp, ki, kd;
  logic [DLIM_W-1:0] drive_lim;
  logic [ILIM_W-1:0] integral_lim;
  int                err_integral;

  tick_t  tick_q[$];
  drive_t drive_expected[$];
  int     ticks_unsent   = 0;
  int     ticks_sent     = 0;
  int     drives_checked = 0;
  int     errors         = 0;
  int     settings_used  = 1;
  int     sat_hits       = 0;
  int     clamp_hits     = 0;
  int     cycle_count    = 0;
  logic   tick_taken     = 1'b0;
  logic   drive_taken    = 1'b0;
  bit     send_burst     = 1'b0;
  bit     recv_burst     = 1'b0;
  int     tick_gap       = 0;
  int     drive_stall    = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // one control tick: wrap, integrate with clamp, weigh, saturate, truncate
  function automatic drive_t next_drive(input int tgt, input int meas, input int rate);
    int     err;
    int     sum;
    int     ilim;
    longint acc;
    longint olim;
    err = tgt - meas;
    while (err > HALF_TURN) err -= FULL_TURN;
    while (err < -HALF_TURN) err += FULL_TURN;
    ilim = int'(integral_lim);
    sum  = err_integral + err;
    if (sum > ilim) begin
      sum = ilim;
      clamp_hits++;
    end else if (sum < -ilim) begin
      sum = -ilim;
      clamp_hits++;
    end
    err_integral = sum;
    acc = longint'(kp) * err + longint'(ki) * sum - longint'(kd) * rate * 8;
    olim = longint'(drive_lim) * (longint'(1) <<< PROD_SHIFT);
    if (acc > olim) begin
      acc = olim;
      sat_hits++;
    end else if (acc < -olim) begin
      acc = -olim;
      sat_hits++;
    end
    return drive_t'(acc / (longint'(1) <<< PROD_SHIFT));
  endfunction

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // present ticks from the pending queue, with a random gap after each
  always @(negedge clk) begin
    tick_t nxt;
    if (!rst_n) begin
      tick_valid <= 1'b0;
      tick_gap   <= 0;
    end else if (!tick_valid || tick_taken) begin
      if (tick_gap != 0) begin
        tick_valid <= 1'b0;
        tick_gap   <= tick_gap - 1;
      end else if (tick_q.size() != 0) begin
        nxt = tick_q.pop_front();
        tick_valid    <= 1'b1;
        tick_target   <= nxt.target;
        tick_measured <= nxt.measured;
        tick_rate     <= nxt.rate;
        tick_gap      <= draw_wait(send_burst);
        if ($urandom_range(0, 31) == 0) send_burst <= !send_burst;
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // receiver stalls for a random count after each drive value
  always @(negedge clk) begin
    int n;
    if (!rst_n) begin
      drive_ready <= 1'b0;
      drive_stall <= 0;
    end else if (drive_taken) begin
      n = draw_wait(recv_burst);
      if (n == 0) begin
        drive_ready <= 1'b1;
      end else begin
        drive_ready <= 1'b0;
        drive_stall <= n - 1;
      end
      if ($urandom_range(0, 31) == 0) recv_burst <= !recv_burst;
    end else if (drive_stall != 0) begin
      drive_ready <= 1'b0;
      drive_stall <= drive_stall - 1;
    end else begin
      drive_ready <= 1'b1;
    end
  end

  // register writes, accepted ticks and drive values at the rising edge
  always @(posedge clk) begin
    drive_t want;
    tick_taken  <= in_if.valid && in_if.ready;
    drive_taken <= out_if.valid && out_if.ready;
    if (!rst_n) begin
      kp           = '0;
      ki           = '0;
      kd           = '0;
      drive_lim    = DLIM_RESET;
      integral_lim = ILIM_RESET;
      err_integral = 0;
      drive_expected.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN_P:         kp = cfg_data[GAIN_W-1:0];
          CFG_GAIN_I:         ki = cfg_data[GAIN_W-1:0];
          CFG_GAIN_D:         kd = cfg_data[GAIN_W-1:0];
          CFG_DRIVE_LIMIT:    drive_lim = cfg_data[DLIM_W-1:0];
          CFG_INTEGRAL_LIMIT: integral_lim = cfg_data[ILIM_W-1:0];
          default: ;
        endcase
      end
      // compare before queuing so a drive never meets its own tick
      if (out_if.valid && out_if.ready) begin
        drives_checked++;
        if (drive_expected.size() == 0) begin
          if (errors < REPORT_MAX)
            $display("tb: drive %0d arrived with no tick outstanding", out_if.drive);
          errors++;
        end else begin
          want = drive_expected.pop_front();
          if (out_if.drive !== want) begin
            if (errors < REPORT_MAX)
              $display("tb: drive mismatch on item %0d: expected %0d, got %0d",
                       drives_checked, want, out_if.drive);
            errors++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        drive_expected.push_back(next_drive(int'(in_if.target_heading),
                                            int'(in_if.measured_heading),
                                            int'(in_if.yaw_rate)));
        ticks_unsent--;
      end
    end
  end

  task automatic send_tick(input int tgt, input int meas, input int rate);
    tick_t t;
    t.target   = ANGLE_W'(tgt);
    t.measured = ANGLE_W'(meas);
    t.rate     = RATE_W'(rate);
    tick_q.push_back(t);
    ticks_unsent++;
    ticks_sent++;
  endtask

  // random tick; bias steers the error to one side so the integral clamps
  task automatic send_random_tick(input int bias);
    int meas;
    int rate;
    meas = int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN;
    rate = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 4000)) - 2000
                                       : int'($urandom);
    case ($urandom_range(0, 7))
      0: send_tick(int'($urandom), int'($urandom), int'($urandom));
      1, 2: send_tick(meas + bias + int'($urandom_range(0, 4000)) - 2000, meas, rate);
      default: send_tick(int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN, meas, rate);
    endcase
  endtask

  // wait until every tick is taken and every drive value has come back
  task automatic drain();
    while (ticks_unsent != 0 || drive_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // all five registers, then junk to the unused indexes
  task automatic load_regs(input logic [CFG_DATA_W-1:0] gp, input logic [CFG_DATA_W-1:0] gi,
                           input logic [CFG_DATA_W-1:0] gd, input logic [CFG_DATA_W-1:0] dl,
                           input logic [CFG_DATA_W-1:0] il);
    put_reg(CFG_GAIN_P, gp);
    put_reg(CFG_GAIN_I, gi);
    put_reg(CFG_GAIN_D, gd);
    put_reg(CFG_DRIVE_LIMIT, dl);
    put_reg(CFG_INTEGRAL_LIMIT, il);
    for (int i = SPARE_INDEX_LO; i < 2 ** CFG_IDX_W; i++)
      put_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // random bits above the register width, which the block must drop
  function automatic logic [CFG_DATA_W-1:0] add_junk(input logic [CFG_DATA_W-1:0] v,
                                                      input int w);
    logic [CFG_DATA_W-1:0] keep;
    keep = (CFG_DATA_W'(1) << w) - 1'b1;
    return (CFG_DATA_W'($urandom) & ~keep) | (v & keep);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CFG_DATA_W'({GAIN_W{1'b1}});
      2: return CFG_DATA_W'($urandom_range(0, 1023));
      default: return CFG_DATA_W'($urandom_range(0, (1 << GAIN_W) - 1));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_integral_limit();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CFG_DATA_W'({ILIM_W{1'b1}});
      2: return CFG_DATA_W'($urandom_range(0, 100000));
      default: return CFG_DATA_W'($urandom_range(0, (1 << ILIM_W) - 1));
    endcase
  endfunction

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] dlim;
    int                    bias;
    // hold reset, then release it at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: zero gains must give zero drive
    send_tick(HALF_TURN, -HALF_TURN, 32767);
    send_tick(-32768, 32767, -32768);
    drain();

    // small gains: wrap edges, half turn kept, out-of-range headings, rate extremes
    load_regs(24'd256, 24'd16, 24'd8, CFG_DATA_W'(DLIM_RESET), CFG_DATA_W'(ILIM_RESET));
    send_tick(HALF_TURN, 0, 0);
    send_tick(0, HALF_TURN, 0);
    send_tick(HALF_TURN + 1, 0, 0);
    send_tick(0, HALF_TURN + 1, 0);
    send_tick(32767, -32768, 0);
    send_tick(-32768, 32767, 0);
    send_tick(HALF_TURN, -HALF_TURN, 0);
    send_tick(0, 0, 32767);
    send_tick(0, 0, -32768);
    drain();

    // full gains: saturation both ways, integral walks into the upper clamp
    load_regs(24'hFF_FFFF, 24'h00_FFFF, 24'h00_FFFF, 24'hFF_FFFF, 24'd50000);
    send_tick(HALF_TURN, 0, -32768);
    send_tick(-HALF_TURN, 0, 32767);
    repeat (3) send_tick(HALF_TURN, 0, 0);
    repeat (3) send_tick(-HALF_TURN, 0, 0);
    drain();

    // zero integral limit keeps the integral at zero
    load_regs(24'hAB_0100, 24'h00_0040, 24'h00_0010, CFG_DATA_W'(DLIM_RESET), 24'd0);
    send_tick(1000, 0, 100);
    send_tick(-1000, 0, -100);
    drain();

    // zero drive limit forces zero drive
    load_regs(24'h00_0100, 24'h00_0040, 24'h00_0010, 24'd0, CFG_DATA_W'(ILIM_RESET));
    send_tick(32767, -32768, 32767);
    send_tick(-HALF_TURN, HALF_TURN, -32768);
    drain();

    // random settings, each phase drained before the next write
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 2))
        0: dlim = '0;
        1: dlim = CFG_DATA_W'(DLIM_RESET);
        default: dlim = CFG_DATA_W'($urandom_range(0, (1 << DLIM_W) - 1));
      endcase
      load_regs(add_junk(pick_gain(), GAIN_W), add_junk(pick_gain(), GAIN_W),
                add_junk(pick_gain(), GAIN_W), add_junk(dlim, DLIM_W),
                add_junk(pick_integral_limit(), ILIM_W));
      bias = int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN;
      for (int k = 0; k < TICKS_PER_PHASE; k++) send_random_tick(bias);
      drain();
    end

    errors += drive_expected.size();
    $display("tb: %0d ticks sent, %0d drive values checked under %0d register settings",
             ticks_sent, drives_checked, settings_used);
    $display("tb: drive saturated %0d times, integral clamped %0d times",
             sat_hits, clamp_hits);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/hpw_pkg.sv
rtl/hpw_intf.sv
rtl/hpw_front.sv
rtl/hpw_queue.sv
rtl/hpw_back.sv
rtl/heading_pid_with_wrap.sv
tb/tb.sv
